### src/btqs_pkg.sv
// ----------------------------------------------------------------------------
// btqs_pkg
// Types and constants shared by the buzzer tone queue sequencer modules.
// ----------------------------------------------------------------------------
package btqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_DIVIDER_DEF = 256;

    localparam int FREQ_W  = 16;
    localparam int DUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CLK_W   = 28;
    localparam int DIV_W   = 9;
    localparam int CNT_OUT_W = 4;
    localparam int CFG_DATA_W = 28;

    localparam logic [FREQ_W-1:0] TOP_MAX = 16'hFFFF;
    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = 28'd125000000;

    // input kind codes
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_MOVIE   = 2'd2;

    // configuration register indexes
    localparam logic CFG_SOUND_EN = 1'b0;
    localparam logic CFG_CLK_HZ   = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  duration_ms;
        logic              movie_mode;
        logic [TIME_W-1:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic                 buzzer_on;
        logic [FREQ_W-1:0]    pwm_top;
        logic [DIV_W-1:0]     pwm_divider;
        logic [FREQ_W-1:0]    pwm_level;
        logic                 top_saturated;
        logic                 tone_active;
        logic [FREQ_W-1:0]    current_freq;
        logic [CNT_OUT_W-1:0] queue_count;
        logic                 request_dropped;
    } t_result;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_req_word;

    typedef struct packed {
        logic      push;
        logic      pop;
        logic      flush;
        t_req_word wdata;
    } t_queue_ctl;

    typedef struct packed {
        logic                 empty;
        logic                 full;
        logic [CNT_OUT_W-1:0] count;
        t_req_word            rdata;
    } t_queue_sts;

    typedef struct packed {
        logic [FREQ_W-1:0] top;
        logic [DIV_W-1:0]  div;
        logic [FREQ_W-1:0] level;
        logic              sat;
    } t_pwm_cfg;

    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_DIV,
        CALC_NORM,
        CALC_DONE
    } t_calc_phase;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_CALC,
        SEQ_DONE
    } t_seq_state;

endpackage

### src/btqs_queue.sv
// ----------------------------------------------------------------------------
// btqs_queue
// Ring queue of tone requests; one slot is kept free to tell full from empty.
// ----------------------------------------------------------------------------
module btqs_queue
    import btqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_ctl i_ctl,
    output t_queue_sts o_sts
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_req_word        r_mem [QUEUE_DEPTH];
    t_req_word        r_rdata;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W-1:0] wr_inc;
    logic [PTR_W-1:0] rd_inc;
    logic [PTR_W:0]   ptr_diff;
    logic [PTR_W-1:0] count;
    logic             full;

    assign wr_inc = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_inc = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    assign full   = (wr_inc == r_rd_ptr);

    assign ptr_diff = {1'b0, r_wr_ptr} - {1'b0, r_rd_ptr};
    assign count = (r_wr_ptr >= r_rd_ptr) ? ptr_diff[PTR_W-1:0]
                 : PTR_W'(ptr_diff + (PTR_W+1)'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_ctl.flush) begin
            n_wr_ptr = '0;
            n_rd_ptr = '0;
        end else begin
            if (i_ctl.push && !full) begin
                n_wr_ptr = wr_inc;
            end
            if (i_ctl.pop) begin
                n_rd_ptr = rd_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && !full && !i_ctl.flush) begin
            r_mem[r_wr_ptr] <= i_ctl.wdata;
        end
        r_rdata <= r_mem[r_rd_ptr];
    end

    assign o_sts.empty = (r_wr_ptr == r_rd_ptr);
    assign o_sts.full  = full;
    assign o_sts.count = CNT_OUT_W'(count);
    assign o_sts.rdata = r_rdata;

endmodule

### src/btqs_pwm_calc.sv
// ----------------------------------------------------------------------------
// btqs_pwm_calc
// PWM setup: bit-serial clk/freq division, then divider doubling one step
// per cycle, then saturation of top and level.
// ----------------------------------------------------------------------------
module btqs_pwm_calc
    import btqs_pkg::*;
#(
    parameter int MAX_DIVIDER = MAX_DIVIDER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CLK_W-1:0]  i_clk_hz,
    input  logic [FREQ_W-1:0] i_freq,
    output logic              o_done,
    output t_pwm_cfg          o_cfg
);

    localparam int STEP_W = $clog2(CLK_W);

    t_calc_phase        r_phase;
    t_calc_phase        n_phase;
    logic [CLK_W-1:0]   r_quo;
    logic [CLK_W-1:0]   n_quo;
    logic [FREQ_W-1:0]  r_rem;
    logic [FREQ_W-1:0]  n_rem;
    logic [FREQ_W-1:0]  r_dsor;
    logic [FREQ_W-1:0]  n_dsor;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   n_div;
    t_pwm_cfg           r_cfg;
    t_pwm_cfg           n_cfg;

    logic [FREQ_W:0]    rem_sh;
    logic [FREQ_W:0]    rem_sub;
    logic               ge;
    logic               last_step;
    logic               need_shift;
    logic [CLK_W-1:0]   wrap;
    logic [CLK_W-1:0]   half;
    logic               sat;

    assign rem_sh    = {r_rem, r_quo[CLK_W-1]};
    assign rem_sub   = rem_sh - {1'b0, r_dsor};
    assign ge        = (rem_sh >= {1'b0, r_dsor});
    assign last_step = (r_step == STEP_W'(CLK_W - 1));
    assign need_shift = (|r_quo[CLK_W-1:FREQ_W]) && (r_div < DIV_W'(MAX_DIVIDER));

    // a zero quotient still gives a wrap of one
    assign wrap = (r_quo == '0) ? CLK_W'(1) : r_quo;
    assign half = wrap >> 1;
    assign sat  = (wrap > CLK_W'(65536));

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            CALC_IDLE: if (i_start) n_phase = CALC_DIV;
            CALC_DIV:  if (last_step) n_phase = CALC_NORM;
            CALC_NORM: if (!need_shift) n_phase = CALC_DONE;
            CALC_DONE: n_phase = CALC_IDLE;
            default:   n_phase = CALC_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsor = r_dsor;
        n_step = r_step;
        n_div  = r_div;
        n_cfg  = r_cfg;
        case (r_phase)
            CALC_IDLE: begin
                n_quo  = i_clk_hz;
                n_rem  = '0;
                n_dsor = i_freq;
                n_step = '0;
                n_div  = DIV_W'(1);
            end
            CALC_DIV: begin
                n_quo  = {r_quo[CLK_W-2:0], ge};
                n_rem  = ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
                n_step = r_step + 1'b1;
            end
            CALC_NORM: begin
                if (need_shift) begin
                    n_quo = r_quo >> 1;
                    n_div = r_div << 1;
                end else begin
                    n_cfg.sat   = sat;
                    n_cfg.top   = sat ? TOP_MAX : FREQ_W'(wrap - 1'b1);
                    n_cfg.level = (|half[CLK_W-1:FREQ_W]) ? TOP_MAX : half[FREQ_W-1:0];
                    n_cfg.div   = r_div;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= CALC_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dsor <= n_dsor;
        r_step <= n_step;
        r_div  <= n_div;
        r_cfg  <= n_cfg;
    end

    // outputs
    always_comb begin
        o_done = (r_phase == CALC_DONE);
        o_cfg  = r_cfg;
    end

endmodule

### src/buzzer_tone_queue_sequencer_unit.sv
// ----------------------------------------------------------------------------
// buzzer_tone_queue_sequencer_unit
// Tone sequencer: request queue, tick handling, movie notes and PWM setup.
//
//   channel   signals                          transfer
//   command   i_start, o_busy, i_cmd           i_start && !o_busy
//   result    o_done, o_res                    o_done, one cycle, no stall
//   config    i_cfg_we, i_cfg_idx, i_cfg_data  i_cfg_we
//
// Requests, plain ticks and silent notes go through the execute and done
// states; the next command can be taken once the unit is back in idle.
// An item that starts a sounding tone adds the PWM setup: execute, 28
// division steps (one quotient bit per cycle), normalize (up to 8 divider
// doublings), the calculator's done phase and the done strobe, before the
// result transfer.
// Reset is synchronous; the queue storage is not cleared.
// The result receiver cannot stall; o_done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module buzzer_tone_queue_sequencer_unit
    import btqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_DIVIDER = MAX_DIVIDER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_cmd                  i_cmd,
    output logic                  o_done,
    output t_result               o_res,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_seq_state         r_state;
    t_seq_state         n_state;
    t_cmd               r_cmd;
    logic               r_sound;
    logic [CLK_W-1:0]   r_clk_hz;
    logic               r_busy_flag;
    logic               n_busy_flag;
    logic               r_timed;
    logic               n_timed;
    logic [TIME_W-1:0]  r_end_time;
    logic [TIME_W-1:0]  n_end_time;
    logic [FREQ_W-1:0]  r_last_freq;
    logic [FREQ_W-1:0]  n_last_freq;
    logic               r_out_en;
    logic               n_out_en;
    t_pwm_cfg           r_pwm;
    t_pwm_cfg           n_pwm;
    logic               r_dropped;
    logic               n_dropped;

    t_queue_ctl         q_ctl;
    t_queue_sts         q_sts;
    logic               calc_go;
    logic [FREQ_W-1:0]  calc_freq;
    logic               calc_done;
    t_pwm_cfg           calc_cfg;

    logic [TIME_W-1:0]  since_end;
    logic               expired;
    logic               busy_after;

    btqs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .o_sts   (q_sts)
    );

    btqs_pwm_calc #(
        .MAX_DIVIDER (MAX_DIVIDER)
    ) u_pwm_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (calc_go),
        .i_clk_hz (r_clk_hz),
        .i_freq   (calc_freq),
        .o_done   (calc_done),
        .o_cfg    (calc_cfg)
    );

    // wrap-safe: end time reached when now - end is not negative
    assign since_end  = r_cmd.now_ms - r_end_time;
    assign expired    = r_busy_flag && r_timed && !since_end[TIME_W-1];
    assign busy_after = r_busy_flag && !expired;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: if (i_start) n_state = SEQ_EXEC;
            SEQ_EXEC: n_state = calc_go ? SEQ_CALC : SEQ_DONE;
            SEQ_CALC: if (calc_done) n_state = SEQ_DONE;
            SEQ_DONE: n_state = SEQ_IDLE;
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // item execution
    always_comb begin
        n_busy_flag = r_busy_flag;
        n_timed     = r_timed;
        n_end_time  = r_end_time;
        n_last_freq = r_last_freq;
        n_out_en    = r_out_en;
        n_pwm       = r_pwm;
        n_dropped   = r_dropped;
        calc_go     = 1'b0;
        calc_freq   = r_cmd.freq_hz;
        q_ctl.push  = 1'b0;
        q_ctl.pop   = 1'b0;
        q_ctl.flush = 1'b0;
        q_ctl.wdata.freq = r_cmd.freq_hz;
        q_ctl.wdata.dur  = r_cmd.duration_ms;

        if (r_state == SEQ_EXEC) begin
            n_dropped = 1'b0;
            case (r_cmd.kind)
                KIND_REQUEST: begin
                    q_ctl.push = 1'b1;
                    n_dropped  = q_sts.full;
                end
                KIND_TICK: begin
                    if (expired) begin
                        n_out_en    = 1'b0;
                        n_busy_flag = 1'b0;
                    end
                    if (r_cmd.movie_mode) begin
                        q_ctl.flush = 1'b1;
                    end else if (!busy_after && !q_sts.empty) begin
                        q_ctl.pop   = 1'b1;
                        calc_freq   = q_sts.rdata.freq;
                        calc_go     = r_sound && (q_sts.rdata.freq != '0);
                        n_last_freq = q_sts.rdata.freq;
                        if (q_sts.rdata.freq != '0) begin
                            n_busy_flag = 1'b1;
                            n_timed     = (q_sts.rdata.dur != '0);
                            n_end_time  = r_cmd.now_ms + TIME_W'(q_sts.rdata.dur);
                        end
                    end
                end
                KIND_MOVIE: begin
                    calc_go = r_sound && (r_cmd.freq_hz != '0);
                    if (!calc_go) begin
                        n_out_en = 1'b0;
                    end
                    n_last_freq = r_cmd.freq_hz;
                    n_busy_flag = 1'b1;
                    n_timed     = 1'b1;
                    n_end_time  = r_cmd.now_ms + TIME_W'(r_cmd.duration_ms);
                end
                default: ;
            endcase
        end else if (r_state == SEQ_CALC && calc_done) begin
            n_out_en = 1'b1;
            n_pwm    = calc_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_busy_flag <= 1'b0;
            r_timed     <= 1'b0;
            r_end_time  <= '0;
            r_last_freq <= '0;
            r_out_en    <= 1'b0;
            r_pwm.top   <= '0;
            r_pwm.div   <= DIV_W'(1);
            r_pwm.level <= '0;
            r_pwm.sat   <= 1'b0;
            r_dropped   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy_flag <= n_busy_flag;
            r_timed     <= n_timed;
            r_end_time  <= n_end_time;
            r_last_freq <= n_last_freq;
            r_out_en    <= n_out_en;
            r_pwm       <= n_pwm;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SEQ_IDLE && i_start) begin
            r_cmd <= i_cmd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound  <= 1'b1;
            r_clk_hz <= CLK_HZ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOUND_EN: r_sound  <= i_cfg_data[0];
                CFG_CLK_HZ:   r_clk_hz <= i_cfg_data[CLK_W-1:0];
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_busy = (r_state != SEQ_IDLE);
        o_done = (r_state == SEQ_DONE);
        o_res.buzzer_on       = r_out_en;
        o_res.pwm_top         = r_pwm.top;
        o_res.pwm_divider     = r_pwm.div;
        o_res.pwm_level       = r_pwm.level;
        o_res.top_saturated   = r_pwm.sat;
        o_res.tone_active     = r_busy_flag;
        o_res.current_freq    = r_last_freq;
        o_res.queue_count     = q_sts.count;
        o_res.request_dropped = r_dropped;
    end

endmodule
